// ===== design/kkq_pkg.sv =====
// ----------------------------------------------------------------------------
// kkq_pkg: shared types and constants for the keypad key qualifier
// Register indexes, reset values, key codes and the config bundle.
// ----------------------------------------------------------------------------
package kkq_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_SETTLE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_INTV = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NOISE_WIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NOISE_LIM = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MUTE     = 3'd4;

    localparam logic [15:0] RST_SETTLE    = 16'd1500;
    localparam logic [15:0] RST_MIN_INTV  = 16'd80;
    localparam logic [15:0] RST_NOISE_WIN = 16'd1000;
    localparam logic [7:0]  RST_NOISE_LIM = 8'd6;
    localparam logic [15:0] RST_MUTE      = 16'd3000;

    localparam logic [7:0] KEY_NONE  = 8'h00;
    localparam logic [7:0] KEY_0     = 8'h30;
    localparam logic [7:0] KEY_9     = 8'h39;
    localparam logic [7:0] KEY_STAR  = 8'h2A;
    localparam logic [7:0] KEY_HASH  = 8'h23;
    localparam logic [7:0] KEY_A     = 8'h41;
    localparam logic [7:0] KEY_D     = 8'h44;
    localparam logic [7:0] COUNT_TOP = 8'hFF;

    typedef struct packed {
        logic [15:0] settle_ms;
        logic [15:0] min_interval_ms;
        logic [15:0] noise_window_ms;
        logic [7:0]  noise_limit;
        logic [15:0] mute_ms;
    } t_cfg;

    typedef struct packed {
        logic        key_valid;
        logic [7:0]  key_code;
        logic        clear_pin;
        logic        ready_res;
        logic        muted;
        logic [31:0] mute_left_ms;
    } t_result;

    function automatic logic key_supported(input logic [7:0] k);
        logic ok;
        ok = (k >= KEY_0 && k <= KEY_9) || (k == KEY_STAR) || (k == KEY_HASH)
            || (k >= KEY_A && k <= KEY_D);
        return ok;
    endfunction

endpackage

// ===== design/kkq_cfg.sv =====
// ----------------------------------------------------------------------------
// kkq_cfg: configuration register file
// Five write-only settings, loaded with their defaults at reset.
// ----------------------------------------------------------------------------
module kkq_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [kkq_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [kkq_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    output kkq_pkg::t_cfg                    o_cfg
);

    kkq_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.settle_ms       <= kkq_pkg::RST_SETTLE;
            r_cfg.min_interval_ms <= kkq_pkg::RST_MIN_INTV;
            r_cfg.noise_window_ms <= kkq_pkg::RST_NOISE_WIN;
            r_cfg.noise_limit     <= kkq_pkg::RST_NOISE_LIM;
            r_cfg.mute_ms         <= kkq_pkg::RST_MUTE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                kkq_pkg::REG_SETTLE:    r_cfg.settle_ms       <= i_cfg_wdata;
                kkq_pkg::REG_MIN_INTV:  r_cfg.min_interval_ms <= i_cfg_wdata;
                kkq_pkg::REG_NOISE_WIN: r_cfg.noise_window_ms <= i_cfg_wdata;
                kkq_pkg::REG_NOISE_LIM: r_cfg.noise_limit     <= i_cfg_wdata[7:0];
                kkq_pkg::REG_MUTE:      r_cfg.mute_ms         <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== design/kkq_engine.sv =====
// ----------------------------------------------------------------------------
// kkq_engine: key qualification state and next-state logic
// Settle, held-key, rate, mute and noise window state; one poll per step.
// ----------------------------------------------------------------------------
module kkq_engine (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [31:0]       i_now_ms,
    input  logic [7:0]        i_raw_key,
    input  kkq_pkg::t_cfg     i_cfg,
    output kkq_pkg::t_result  o_res
);

    logic        r_armed;
    logic [31:0] r_ready_at;
    logic [7:0]  r_held_key;
    logic [31:0] r_mute_until;
    logic [31:0] r_last_accept;
    logic [31:0] r_win_start;
    logic [7:0]  r_noise_cnt;

    logic        n_armed;
    logic [31:0] n_ready_at;
    logic [7:0]  n_held_key;
    logic [31:0] n_mute_until;
    logic [31:0] n_last_accept;
    logic [31:0] n_win_start;
    logic [7:0]  n_noise_cnt;

    logic [32:0] ready_sum;
    logic [32:0] mute_sum;
    logic        settled;
    logic        mute_active;
    logic        too_soon;
    logic        win_open;
    logic [31:0] since_last;
    logic [31:0] since_win;
    logic [7:0]  cnt_base;
    logic [7:0]  cnt_inc;
    logic        new_key;
    logic        qualified;
    logic        mute_start;

    always_comb begin
        ready_sum   = {1'b0, i_now_ms} + {17'd0, i_cfg.settle_ms};
        mute_sum    = {1'b0, i_now_ms} + {17'd0, i_cfg.mute_ms};
        // a freshly armed deadline has passed if it wrapped or is zero away
        if (!r_armed) begin
            settled = ready_sum[32] || (i_cfg.settle_ms == 16'd0);
        end else begin
            settled = (i_now_ms >= r_ready_at);
        end
        mute_active = (r_mute_until > i_now_ms);
        since_last  = i_now_ms - r_last_accept;
        since_win   = i_now_ms - r_win_start;
        too_soon    = (since_last < {16'd0, i_cfg.min_interval_ms});
        win_open    = (r_win_start == 32'd0) || (since_win > {16'd0, i_cfg.noise_window_ms});
        cnt_base    = win_open ? 8'd0 : r_noise_cnt;
        cnt_inc     = (cnt_base == kkq_pkg::COUNT_TOP) ? cnt_base : cnt_base + 8'd1;
        new_key     = settled && (i_raw_key != kkq_pkg::KEY_NONE) && (r_held_key != i_raw_key);
        qualified   = new_key && kkq_pkg::key_supported(i_raw_key) && !mute_active && !too_soon;
        mute_start  = qualified && (cnt_inc > i_cfg.noise_limit);

        n_armed       = 1'b1;
        n_ready_at    = r_armed ? r_ready_at : ready_sum[31:0];
        n_held_key    = r_held_key;
        n_mute_until  = r_mute_until;
        n_last_accept = r_last_accept;
        n_win_start   = r_win_start;
        n_noise_cnt   = r_noise_cnt;

        if (settled) begin
            n_held_key = i_raw_key;
        end
        if (mute_start) begin
            n_mute_until = mute_sum[31:0];
            n_win_start  = 32'd0;
            n_noise_cnt  = 8'd0;
        end else if (qualified) begin
            n_win_start   = win_open ? i_now_ms : r_win_start;
            n_noise_cnt   = cnt_inc;
            n_last_accept = i_now_ms;
        end

        o_res.key_valid = qualified && !mute_start;
        o_res.key_code  = o_res.key_valid ? i_raw_key : kkq_pkg::KEY_NONE;
        o_res.clear_pin = mute_start;
        o_res.ready_res = settled;
        // new deadline lies after now unless it wrapped or mute_ms is zero
        if (mute_start) begin
            o_res.muted        = !mute_sum[32] && (i_cfg.mute_ms != 16'd0);
            o_res.mute_left_ms = o_res.muted ? {16'd0, i_cfg.mute_ms} : 32'd0;
        end else begin
            o_res.muted        = mute_active;
            o_res.mute_left_ms = mute_active ? (r_mute_until - i_now_ms) : 32'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed       <= 1'b0;
            r_ready_at    <= 32'd0;
            r_held_key    <= kkq_pkg::KEY_NONE;
            r_mute_until  <= 32'd0;
            r_last_accept <= 32'd0;
            r_win_start   <= 32'd0;
            r_noise_cnt   <= 8'd0;
        end else if (i_step) begin
            r_armed       <= n_armed;
            r_ready_at    <= n_ready_at;
            r_held_key    <= n_held_key;
            r_mute_until  <= n_mute_until;
            r_last_accept <= n_last_accept;
            r_win_start   <= n_win_start;
            r_noise_cnt   <= n_noise_cnt;
        end
    end

endmodule

// ===== design/keypad_key_qualifier_core.sv =====
// ----------------------------------------------------------------------------
// keypad_key_qualifier_core: polled keypad key qualifier
// Settle delay, held-key suppression, rate limit and noise mute per poll.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: i_in_valid / o_in_stall carry one poll word (timestamp in
//   ms and raw key code). Output channel: o_out_valid / i_out_stall carry one
//   result word per poll, in poll order.
//   A word is taken when valid is high and stall is low at a clock edge.
//   A poll passes an input register, the qualification logic and the result
//   register from input accept to output valid. Throughput is one poll per
//   cycle while the receiver does not stall; the qualifier state is updated
//   in the same cycle the result register loads, so the next poll sees it
//   directly. On a receiver stall the result register holds its word and
//   an empty input register takes one more poll; then o_in_stall rises.
//   Settings are written through i_cfg_we / i_cfg_idx / i_cfg_wdata while
//   no poll is in flight; unknown indexes are ignored.
//   Reset (i_rst_n low, synchronous) empties both registers, clears all
//   qualifier state and loads the default settings.
// ----------------------------------------------------------------------------
module keypad_key_qualifier_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [kkq_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [kkq_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [31:0]                     i_now_ms,
    input  logic [7:0]                      i_raw_key,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_key_valid,
    output logic [7:0]                      o_key_code,
    output logic                            o_clear_pin,
    output logic                            o_ready_res,
    output logic                            o_muted,
    output logic [31:0]                     o_mute_left_ms
);

    kkq_pkg::t_cfg    cfg;
    kkq_pkg::t_result res;

    logic        r_in_valid;
    logic [31:0] r_now_ms;
    logic [7:0]  r_raw_key;
    logic        r_out_valid;
    kkq_pkg::t_result r_res;

    logic advance;
    logic in_take;

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    kkq_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    kkq_engine u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (advance),
        .i_now_ms  (r_now_ms),
        .i_raw_key (r_raw_key),
        .i_cfg     (cfg),
        .o_res     (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_now_ms  <= i_now_ms;
            r_raw_key <= i_raw_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res <= res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_key_valid    = r_res.key_valid;
    assign o_key_code     = r_res.key_code;
    assign o_clear_pin    = r_res.clear_pin;
    assign o_ready_res    = r_res.ready_res;
    assign o_muted        = r_res.muted;
    assign o_mute_left_ms = r_res.mute_left_ms;

    // a mute-start poll never also delivers a key
    a_key_xor_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_key_valid && o_clear_pin))
        else $error("key event and pin clear on the same word");

    // a key event only after settling, and with a real code
    a_key_settled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_key_valid) |-> (o_ready_res && o_key_code != kkq_pkg::KEY_NONE))
        else $error("key event before settle or with empty code");

    // remaining mute time agrees with the mute flag
    a_mute_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_muted == (o_mute_left_ms != 32'd0)))
        else $error("mute flag and remaining time disagree");

    // a stalled result is not dropped
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("stalled result word lost");

endmodule
